// ===== rtl/skt_pkg.sv =====
`timescale 1ns / 1ps

package skt_pkg;

  localparam int unsigned MaxEntriesDefault = 64;
  localparam int unsigned KeyBitsDefault    = 64;
  localparam int unsigned OffsetBitsDefault = 32;

  localparam int unsigned KeyPortBits    = 64;
  localparam int unsigned OffsetPortBits = 32;
  localparam int unsigned StatusBits     = 3;
  localparam int unsigned CountPortBits  = 7;

  typedef enum logic [StatusBits-1:0] {
    ST_UPDATED  = 3'd0,
    ST_INSERTED = 3'd1,
    ST_FULL     = 3'd2,
    ST_FOUND    = 3'd3,
    ST_MISSING  = 3'd4
  } status_e;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic cmp;  // latch compare flags against the incoming key
    logic ins;  // shift larger keys up and place the new key
    logic upd;  // overwrite the offset of the matching entry
  } cell_ctrl_t;

endpackage

// ===== rtl/sorted_key_table_upsert_core.sv =====
`timescale 1ns / 1ps

// Channel   Handshake                  Payload
// input     in_valid_i / in_stall_o    mode_i, key_i, rec_offset_i
// output    out_valid_o / out_stall_i  status_o, found_offset_o, entry_count_o
//
// In each operation, every cell compares its key with the incoming one in the
// transfer cycle, and in the next cycle the cells shift or update and the
// result is loaded into the output register.
// A new item is taken again from the cycle after the update.
// Reset empties the table at once; stored keys need no clearing.
// A held result stalls the input only while it is itself stalled.

module sorted_key_table_upsert_core
  import skt_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = MaxEntriesDefault,
  parameter int unsigned KEY_BITS    = KeyBitsDefault,
  parameter int unsigned OFFSET_BITS = OffsetBitsDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      mode_i,
  input  logic [KeyPortBits-1:0]    key_i,
  input  logic [OffsetPortBits-1:0] rec_offset_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [StatusBits-1:0]     status_o,
  output logic [OffsetPortBits-1:0] found_offset_o,
  output logic [CountPortBits-1:0]  entry_count_o
);

  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_UPD  = 2'b10
  } state_e;

  state_e state_q, state_d;

  logic in_xfer, out_xfer;
  logic [KEY_BITS-1:0]    in_key;
  logic [63:0]            in_off_ext;
  logic [OFFSET_BITS-1:0] in_off;

  logic                   mode_q;
  logic [KEY_BITS-1:0]    key_q;
  logic [OFFSET_BITS-1:0] off_q;
  logic [CNT_W-1:0]       count_q, count_d;

  logic                      out_valid_q, out_valid_d;
  status_e                   status_q, status_d;
  logic [OffsetPortBits-1:0] found_q, found_d;
  logic [CountPortBits-1:0]  ecount_q, ecount_d;

  cell_ctrl_t ctrl;
  logic [MAX_ENTRIES-1:0]   lt_w, eq_w;
  logic [KEY_BITS-1:0]      key_w [MAX_ENTRIES];
  logic [OFFSET_BITS-1:0]   off_w [MAX_ENTRIES];

  logic                   hit, full, do_ins;
  logic [OFFSET_BITS-1:0] hit_off;
  logic [63:0]            hit_off_ext;
  logic [15:0]            cnt_ext;

  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_xfer   = out_valid_o && !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || (out_valid_q && out_stall_i);

  assign in_key     = key_i[KEY_BITS-1:0];
  assign in_off_ext = 64'(rec_offset_i);
  assign in_off     = in_off_ext[OFFSET_BITS-1:0];

  assign hit    = |eq_w;
  assign full   = count_q == CNT_W'(MAX_ENTRIES);
  assign do_ins = (state_q == S_UPD) && !mode_q && !hit && !full;

  assign ctrl.cmp = in_xfer;
  assign ctrl.ins = do_ins;
  assign ctrl.upd = (state_q == S_UPD) && !mode_q && hit;

  // At most one cell matches, so an AND-OR tree selects its offset.
  always_comb begin
    hit_off = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      hit_off = hit_off | (eq_w[i] ? off_w[i] : '0);
    end
  end

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    logic                   prev_lt;
    logic [KEY_BITS-1:0]    prev_key;
    logic [OFFSET_BITS-1:0] prev_off;
    if (g == 0) begin : g_head
      assign prev_lt  = 1'b1;
      assign prev_key = '0;
      assign prev_off = '0;
    end else begin : g_body
      assign prev_lt  = lt_w[g-1];
      assign prev_key = key_w[g-1];
      assign prev_off = off_w[g-1];
    end
    skt_cell #(
      .IDX        (g),
      .KEY_BITS   (KEY_BITS),
      .OFFSET_BITS(OFFSET_BITS),
      .CNT_W      (CNT_W)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .count_i   (count_q),
      .cmp_key_i (in_key),
      .new_key_i (key_q),
      .new_off_i (off_q),
      .prev_lt_i (prev_lt),
      .prev_key_i(prev_key),
      .prev_off_i(prev_off),
      .lt_o      (lt_w[g]),
      .eq_o      (eq_w[g]),
      .key_o     (key_w[g]),
      .off_o     (off_w[g])
    );
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    out_valid_d = out_valid_q;
    status_d    = status_q;
    found_d     = found_q;
    ecount_d    = ecount_q;
    hit_off_ext = 64'(hit_off);
    cnt_ext     = 16'(count_q);
    if (out_xfer) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        state_d     = S_IDLE;
        out_valid_d = 1'b1;
        found_d     = '0;
        if (mode_q) begin
          if (hit) begin
            status_d = ST_FOUND;
            found_d  = hit_off_ext[OffsetPortBits-1:0];
          end else begin
            status_d = ST_MISSING;
          end
        end else if (hit) begin
          status_d = ST_UPDATED;
        end else if (full) begin
          status_d = ST_FULL;
        end else begin
          status_d = ST_INSERTED;
          count_d  = count_q + CNT_W'(1);
          cnt_ext  = 16'(count_d);
        end
        ecount_d = cnt_ext[CountPortBits-1:0];
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    found_q  <= found_d;
    ecount_q <= ecount_d;
    if (in_xfer) begin
      mode_q <= mode_i;
      key_q  <= in_key;
      off_q  <= in_off;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign found_offset_o = found_q;
  assign entry_count_o  = ecount_q;

endmodule

// ===== rtl/skt_cell.sv =====
`timescale 1ns / 1ps

module skt_cell
  import skt_pkg::*;
#(
  parameter int unsigned IDX         = 0,
  parameter int unsigned KEY_BITS    = KeyBitsDefault,
  parameter int unsigned OFFSET_BITS = OffsetBitsDefault,
  parameter int unsigned CNT_W       = 7
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cell_ctrl_t             ctrl_i,
  input  logic [CNT_W-1:0]       count_i,
  input  logic [KEY_BITS-1:0]    cmp_key_i,
  input  logic [KEY_BITS-1:0]    new_key_i,
  input  logic [OFFSET_BITS-1:0] new_off_i,
  input  logic                   prev_lt_i,
  input  logic [KEY_BITS-1:0]    prev_key_i,
  input  logic [OFFSET_BITS-1:0] prev_off_i,
  output logic                   lt_o,
  output logic                   eq_o,
  output logic [KEY_BITS-1:0]    key_o,
  output logic [OFFSET_BITS-1:0] off_o
);

  logic                   used;
  logic                   lt_q, lt_d, eq_q, eq_d;
  logic [KEY_BITS-1:0]    key_q, key_d;
  logic [OFFSET_BITS-1:0] off_q, off_d;

  assign used = CNT_W'(IDX) < count_i;

  always_comb begin
    lt_d  = lt_q;
    eq_d  = eq_q;
    key_d = key_q;
    off_d = off_q;
    if (ctrl_i.cmp) begin
      lt_d = used && (key_q < cmp_key_i);
      eq_d = used && (key_q == cmp_key_i);
    end
    if (ctrl_i.ins) begin
      // Keys are sorted, so the cells below the new key form a prefix.
      if (prev_lt_i && !lt_q) begin
        key_d = new_key_i;
        off_d = new_off_i;
      end else if (!prev_lt_i) begin
        key_d = prev_key_i;
        off_d = prev_off_i;
      end
    end
    if (ctrl_i.upd && eq_q) begin
      off_d = new_off_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q <= 1'b0;
      eq_q <= 1'b0;
    end else begin
      lt_q <= lt_d;
      eq_q <= eq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    off_q <= off_d;
  end

  assign lt_o  = lt_q;
  assign eq_o  = eq_q;
  assign key_o = key_q;
  assign off_o = off_q;

endmodule

// ===== rtl/skt_checker.sv =====
`timescale 1ns / 1ps

module skt_checker
  import skt_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = MaxEntriesDefault
) (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic [StatusBits-1:0]     status_o,
  input logic [OffsetPortBits-1:0] found_offset_o,
  input logic [CountPortBits-1:0]  entry_count_o
);

  logic in_xfer;
  assign in_xfer = in_valid_i && !in_stall_o;

  // The cells are busy in the cycle after a transfer.
  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> in_stall_o)
    else $error("input taken while the table is updating");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |-> ##2 out_valid_o)
    else $error("no result two cycles after an input transfer");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o <= ST_MISSING))
    else $error("undefined status code");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((MAX_ENTRIES > 127) || (entry_count_o <= MAX_ENTRIES)))
    else $error("entry count above table size");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(status_o) && $stable(found_offset_o)
       && $stable(entry_count_o)))
    else $error("stalled result changed");

endmodule

bind sorted_key_table_upsert_core skt_checker #(
  .MAX_ENTRIES(MAX_ENTRIES)
) u_skt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .status_o      (status_o),
  .found_offset_o(found_offset_o),
  .entry_count_o (entry_count_o)
);

// ===== test/tb_sorted_key_table_upsert_core.sv =====
`timescale 1ns / 1ps

module tb_sorted_key_table_upsert_core;
  import skt_pkg::*;

  localparam int unsigned TableDepth = MaxEntriesDefault;
  localparam int unsigned StallLimit = 5000;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned ItemsPerPhase = 633;

  typedef struct {
    status_e                   status;
    logic [OffsetPortBits-1:0] found_offset;
    logic [CountPortBits-1:0]  entry_count;
  } table_reply_t;

  // Mirror of the sorted node plus the replies that are still owed by the block.
  class key_table_board;
    logic [KeyPortBits-1:0]    key_mirror[TableDepth];
    logic [OffsetPortBits-1:0] offset_mirror[TableDepth];
    int unsigned               mirror_count;
    table_reply_t              replies_due[$];
    int unsigned               errors;

    function new();
      mirror_count = 0;
      errors = 0;
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch: %s got %0h expected %0h", what, got, want);
      errors++;
    endtask

    function void note_op(logic search, logic [KeyPortBits-1:0] k,
                          logic [OffsetPortBits-1:0] d);
      int unsigned  pos;
      int unsigned  i;
      bit           hit;
      table_reply_t r;
      pos = 0;
      while (pos < mirror_count && key_mirror[pos] < k) pos++;
      hit = (pos < mirror_count) && (key_mirror[pos] == k);
      r.found_offset = '0;
      if (search) begin
        if (hit) begin
          r.status = ST_FOUND;
          r.found_offset = offset_mirror[pos];
        end else begin
          r.status = ST_MISSING;
        end
      end else if (hit) begin
        offset_mirror[pos] = d;
        r.status = ST_UPDATED;
      end else if (mirror_count >= TableDepth) begin
        r.status = ST_FULL;
      end else begin
        for (i = mirror_count; i > pos; i--) begin
          key_mirror[i] = key_mirror[i-1];
          offset_mirror[i] = offset_mirror[i-1];
        end
        key_mirror[pos] = k;
        offset_mirror[pos] = d;
        mirror_count++;
        r.status = ST_INSERTED;
      end
      r.entry_count = mirror_count[CountPortBits-1:0];
      replies_due.push_back(r);
    endfunction

    task check_reply(logic [StatusBits-1:0] st, logic [OffsetPortBits-1:0] fo,
                     logic [CountPortBits-1:0] cnt);
      table_reply_t r;
      if (replies_due.size() == 0) begin
        report("result with nothing outstanding, status", 64'(st), '0);
      end else begin
        r = replies_due.pop_front();
        if (st !== r.status) report("status", 64'(st), 64'(r.status));
        if (fo !== r.found_offset) begin
          report("found_offset", 64'(fo), 64'(r.found_offset));
        end
        if (cnt !== r.entry_count) begin
          report("entry_count", 64'(cnt), 64'(r.entry_count));
        end
      end
    endtask
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall_o;
  logic                      mode = 1'b0;
  logic [KeyPortBits-1:0]    key = '0;
  logic [OffsetPortBits-1:0] rec_offset = '0;
  logic                      out_valid_o;
  logic                      out_stall = 1'b1;
  logic [StatusBits-1:0]     status_o;
  logic [OffsetPortBits-1:0] found_offset_o;
  logic [CountPortBits-1:0]  entry_count_o;

  int unsigned    send_idle_pct = 11;
  int unsigned    recv_idle_pct = 71;
  int unsigned    quiet_cycles = 0;
  key_table_board board;

  sorted_key_table_upsert_core DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall_o),
    .mode_i        (mode),
    .key_i         (key),
    .rec_offset_i  (rec_offset),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall),
    .status_o      (status_o),
    .found_offset_o(found_offset_o),
    .entry_count_o (entry_count_o)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: check every output transfer and draw the next stall.
  always @(posedge clk) begin
    if (rst_n && out_valid_o && !out_stall) begin
      board.check_reply(status_o, found_offset_o, entry_count_o);
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic send_op(input logic search, input logic [KeyPortBits-1:0] k,
                         input logic [OffsetPortBits-1:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= search;
    key <= k;
    rec_offset <= d;
    do @(posedge clk); while (in_stall_o);
    board.note_op(search, k, d);
  endtask

  function automatic logic [KeyPortBits-1:0] pick_key();
    logic [KeyPortBits-1:0] k;
    logic [KeyPortBits-1:0] one_bit;
    int unsigned            sel;
    sel = $urandom_range(9);
    one_bit = 64'd1 << $urandom_range(KeyPortBits - 1);
    k = {$urandom, $urandom};
    if (board.mirror_count != 0 && sel <= 3) begin
      k = board.key_mirror[$urandom_range(board.mirror_count - 1)];
    end else if (board.mirror_count != 0 && sel == 4) begin
      // Just beside a stored key, so the search lands between neighbors.
      k = board.key_mirror[$urandom_range(board.mirror_count - 1)];
      k = $urandom_range(1) ? k + 64'd1 : k - 64'd1;
    end else if (sel == 5) begin
      k = 64'($urandom_range(255));
    end else if (sel == 6) begin
      case ($urandom_range(3))
        0: k = '0;
        1: k = '1;
        2: k = one_bit;
        default: k = ~one_bit;
      endcase
    end
    return k;
  endfunction

  function automatic logic [OffsetPortBits-1:0] pick_offset();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    board = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty table, ends of the key range, ordering, update, search.
    send_op(1'b1, 64'd0, 32'd0);
    send_op(1'b1, '1, '1);
    send_op(1'b0, 64'h8000_0000_0000_0000, '1);
    send_op(1'b0, 64'd0, 32'd0);
    send_op(1'b0, '1, 32'h1234_5678);
    send_op(1'b0, 64'h4142_4300_0000_0000, 32'd1);
    send_op(1'b0, 64'h4142_0000_0000_0000, 32'h5555_5555);
    send_op(1'b1, 64'd0, 32'hAAAA_AAAA);
    send_op(1'b1, '1, 32'd0);
    send_op(1'b1, 64'h4142_4300_0000_0000, '1);
    send_op(1'b1, 64'h4142_4400_0000_0000, 32'd0);
    send_op(1'b0, 64'd0, '1);
    send_op(1'b1, 64'd0, 32'd0);
    send_op(1'b0, '1, 32'd0);
    send_op(1'b1, '1, 32'd7);
    send_op(1'b1, 64'h7FFF_FFFF_FFFF_FFFF, 32'd0);

    // Fill the node with random new keys.
    while (board.mirror_count < TableDepth) begin
      send_op(1'b0, {$urandom, $urandom}, pick_offset());
    end

    // Full node: a new key is turned away, a stored one is still updated.
    send_op(1'b0, 64'h0000_0000_0000_0001, 32'hDEAD_BEEF);
    send_op(1'b0, board.key_mirror[0], 32'hCAFE_F00D);
    send_op(1'b0, board.key_mirror[TableDepth-1], '1);
    send_op(1'b1, board.key_mirror[0], 32'd0);
    send_op(1'b1, board.key_mirror[TableDepth-1], 32'd0);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 11;
          recv_idle_pct = 71;
        end
        1: begin
          send_idle_pct = 71;
          recv_idle_pct = 11;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      repeat (ItemsPerPhase) send_op($urandom_range(1), pick_key(), pick_offset());
    end
    in_valid <= 1'b0;

    while (board.replies_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (board.replies_due.size() != 0) begin
      board.report("results never delivered", 64'(board.replies_due.size()), '0);
    end

    if (board.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
